// ===== design/planar_three_body_derivative_macros.svh =====
// assertion macros shared by the planar three-body derivative checker
// no dependencies; included by the checker file only
`ifndef PLANAR_THREE_BODY_DERIVATIVE_MACROS_SVH
`define PLANAR_THREE_BODY_DERIVATIVE_MACROS_SVH

// same-cycle implication, disabled during reset
`define PTBD_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define PTBD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

// next-cycle implication that also holds across reset
`define PTBD_ASSERT_RST(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/ptbd_pkg.sv =====
// widths, latencies and payload types of the planar three-body derivative
// no dependencies; used by the interfaces, the pair unit and the top level
package ptbd_pkg;

    localparam int FRAC_BITS = 47;
    localparam int WORD_W    = 64;
    localparam int DIFF_W    = WORD_W + 2;            // 2*a + b of two words
    localparam int MAG_W     = DIFF_W - 1;
    localparam int D2_W      = 2 * MAG_W + 1;         // dx^2 + dy^2
    localparam int SQ_SHIFT  = 128;                   // d2 scaled before the root
    localparam int SQRT_W    = (D2_W + SQ_SHIFT + 1) / 2;
    localparam int REM_W     = 2 * SQRT_W;
    localparam int LIMB_W    = 32;
    localparam int D2_LIMBS  = (D2_W + LIMB_W - 1) / LIMB_W;
    localparam int S_LIMBS   = (SQRT_W + LIMB_W - 1) / LIMB_W;
    localparam int ROW_W     = LIMB_W * (S_LIMBS + 1);
    localparam int HALF_N    = (D2_LIMBS + 1) / 2;
    localparam int HALF_W    = ROW_W + LIMB_W + 1;
    localparam int ACC_W     = LIMB_W * (D2_LIMBS + S_LIMBS);
    localparam int DEN_W     = D2_W + SQRT_W;
    localparam int QUO_W     = WORD_W - 1;            // quotient bits below the clamp
    localparam int NUM_SHIFT = 3 * FRAC_BITS + 64 - QUO_W;
    localparam int PREM_W    = DEN_W + 1;
    localparam int TERM_W    = QUO_W + 2;
    localparam int SUM_W     = TERM_W + 2;

    // abs, products, squares, d2, root, 4 multiply stages, clamp, divide, term
    localparam int CLAMP_STAGE = 4 + SQRT_W + 4 + 1;
    localparam int PAIR_LAT    = CLAMP_STAGE + QUO_W + 1;
    // difference stage in front, sum and saturate stages behind
    localparam int LAT         = PAIR_LAT + 3;

    typedef logic signed [WORD_W-1:0] t_word;
    typedef logic signed [DIFF_W-1:0] t_diff;
    typedef logic signed [TERM_W-1:0] t_term;

endpackage

// ===== design/ptbd_if.sv =====
// request and result channels of the planar three-body derivative
// depends on ptbd_pkg for the field types
interface ptbd_in_if;
    logic            valid;
    logic            ready;
    ptbd_pkg::t_word pos_x1;
    ptbd_pkg::t_word pos_y1;
    ptbd_pkg::t_word pos_x2;
    ptbd_pkg::t_word pos_y2;
    ptbd_pkg::t_word mom_x1;
    ptbd_pkg::t_word mom_y1;
    ptbd_pkg::t_word mom_x2;
    ptbd_pkg::t_word mom_y2;

    modport source (
        output valid, pos_x1, pos_y1, pos_x2, pos_y2, mom_x1, mom_y1, mom_x2, mom_y2,
        input  ready
    );
    modport sink (
        input  valid, pos_x1, pos_y1, pos_x2, pos_y2, mom_x1, mom_y1, mom_x2, mom_y2,
        output ready
    );
endinterface

interface ptbd_out_if;
    logic            valid;
    logic            ready;
    ptbd_pkg::t_word rate_x1;
    ptbd_pkg::t_word rate_y1;
    ptbd_pkg::t_word rate_x2;
    ptbd_pkg::t_word rate_y2;
    ptbd_pkg::t_word force_x1;
    ptbd_pkg::t_word force_y1;
    ptbd_pkg::t_word force_x2;
    ptbd_pkg::t_word force_y2;
    logic            range_fault;

    modport source (
        output valid, rate_x1, rate_y1, rate_x2, rate_y2,
               force_x1, force_y1, force_x2, force_y2, range_fault,
        input  ready
    );
    modport sink (
        input  valid, rate_x1, rate_y1, rate_x2, rate_y2,
               force_x1, force_y1, force_x2, force_y2, range_fault,
        output ready
    );
endinterface

// ===== design/ptbd_pair.sv =====
// one pair term: d / |d|^3 for a planar difference vector, fully pipelined
// depends on ptbd_pkg; instantiated three times by the top level
module ptbd_pair (
    input  logic            i_clk,
    input  logic            i_en,
    input  ptbd_pkg::t_diff i_dx,
    input  ptbd_pkg::t_diff i_dy,
    output ptbd_pkg::t_term o_tx,
    output ptbd_pkg::t_term o_ty,
    output logic            o_fault
);
    localparam int DIFF_W = ptbd_pkg::DIFF_W;
    localparam int MAG_W  = ptbd_pkg::MAG_W;
    localparam int D2_W   = ptbd_pkg::D2_W;
    localparam int SQRT_W = ptbd_pkg::SQRT_W;
    localparam int REM_W  = ptbd_pkg::REM_W;
    localparam int LIMB_W = ptbd_pkg::LIMB_W;
    localparam int D2P_W  = LIMB_W * ptbd_pkg::D2_LIMBS;
    localparam int SP_W   = LIMB_W * ptbd_pkg::S_LIMBS;
    localparam int DEN_W  = ptbd_pkg::DEN_W;
    localparam int PREM_W = ptbd_pkg::PREM_W;
    localparam int QUO_W  = ptbd_pkg::QUO_W;
    localparam int TERM_W = ptbd_pkg::TERM_W;
    localparam int SIDE_N = ptbd_pkg::PAIR_LAT - 1;

    typedef struct packed {
        logic             sx;
        logic             sy;
        logic [MAG_W-1:0] ax;
        logic [MAG_W-1:0] ay;
    } t_side;

    // signs and magnitudes ride along the whole pipe
    t_side r_side [1:SIDE_N];

    // stage 1: magnitudes
    logic [DIFF_W-1:0] n_absx, n_absy;
    always_comb begin
        n_absx = i_dx[DIFF_W-1] ? DIFF_W'(-i_dx) : DIFF_W'(i_dx);
        n_absy = i_dy[DIFF_W-1] ? DIFF_W'(-i_dy) : DIFF_W'(i_dy);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_side[1].sx <= i_dx[DIFF_W-1];
            r_side[1].sy <= i_dy[DIFF_W-1];
            r_side[1].ax <= n_absx[MAG_W-1:0];
            r_side[1].ay <= n_absy[MAG_W-1:0];
            for (int k = 2; k <= SIDE_N; k++) begin
                r_side[k] <= r_side[k-1];
            end
        end
    end

    // stage 2: 32x32 partial products of the low 64 magnitude bits
    logic [2*LIMB_W-1:0] r_px00, r_px01, r_px11, r_py00, r_py01, r_py11;
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_px00 <= r_side[1].ax[LIMB_W-1:0] * r_side[1].ax[LIMB_W-1:0];
            r_px01 <= r_side[1].ax[LIMB_W-1:0] * r_side[1].ax[2*LIMB_W-1:LIMB_W];
            r_px11 <= r_side[1].ax[2*LIMB_W-1:LIMB_W] * r_side[1].ax[2*LIMB_W-1:LIMB_W];
            r_py00 <= r_side[1].ay[LIMB_W-1:0] * r_side[1].ay[LIMB_W-1:0];
            r_py01 <= r_side[1].ay[LIMB_W-1:0] * r_side[1].ay[2*LIMB_W-1:LIMB_W];
            r_py11 <= r_side[1].ay[2*LIMB_W-1:LIMB_W] * r_side[1].ay[2*LIMB_W-1:LIMB_W];
        end
    end

    // stage 3: squares; top magnitude bit adds L<<65 + 2^128
    logic [D2_W-1:0] n_sqx, n_sqy, r_sqx, r_sqy, r_d2;
    always_comb begin
        n_sqx = D2_W'({r_px11, r_px00}) + (D2_W'(r_px01) << (LIMB_W + 1));
        if (r_side[2].ax[MAG_W-1]) begin
            n_sqx = n_sqx + (D2_W'(r_side[2].ax[2*LIMB_W-1:0]) << (2*LIMB_W + 1))
                          + (D2_W'(1) << (4*LIMB_W));
        end
        n_sqy = D2_W'({r_py11, r_py00}) + (D2_W'(r_py01) << (LIMB_W + 1));
        if (r_side[2].ay[MAG_W-1]) begin
            n_sqy = n_sqy + (D2_W'(r_side[2].ay[2*LIMB_W-1:0]) << (2*LIMB_W + 1))
                          + (D2_W'(1) << (4*LIMB_W));
        end
    end

    // stage 4: squared distance
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sqx <= n_sqx;
            r_sqy <= n_sqy;
            r_d2  <= r_sqx + r_sqy;
        end
    end

    // root stages: one result bit each, remainder form
    logic [REM_W-1:0]  r_rem [SQRT_W];
    logic [SQRT_W-1:0] r_s   [SQRT_W];
    logic [D2_W-1:0]   r_d2s [SQRT_W];

    for (genvar k = 0; k < SQRT_W; k++) begin : g_sqrt
        localparam int B = SQRT_W - 1 - k;
        logic [REM_W-1:0]  w_rem_in;
        logic [REM_W-1:0]  w_trial;
        logic [SQRT_W-1:0] w_s_in;
        logic [D2_W-1:0]   w_d2_in;
        if (k == 0) begin : g_first
            assign w_rem_in = REM_W'(r_d2) << ptbd_pkg::SQ_SHIFT;
            assign w_s_in   = '0;
            assign w_d2_in  = r_d2;
        end else begin : g_next
            assign w_rem_in = r_rem[k-1];
            assign w_s_in   = r_s[k-1];
            assign w_d2_in  = r_d2s[k-1];
        end
        // (2s + 2^b) * 2^b, the bits never overlap
        assign w_trial = (REM_W'(w_s_in) << (B + 1)) | (REM_W'(1) << (2 * B));
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (w_rem_in >= w_trial) begin
                    r_rem[k] <= w_rem_in - w_trial;
                    r_s[k]   <= w_s_in | (SQRT_W'(1) << B);
                end else begin
                    r_rem[k] <= w_rem_in;
                    r_s[k]   <= w_s_in;
                end
                r_d2s[k] <= w_d2_in;
            end
        end
    end

    // denominator d2 * s: limb products, rows, half sums, total
    logic [D2P_W-1:0] w_d2p;
    logic [SP_W-1:0]  w_sp;
    assign w_d2p = D2P_W'(r_d2s[SQRT_W-1]);
    assign w_sp  = SP_W'(r_s[SQRT_W-1]);

    logic [2*LIMB_W-1:0] r_pp [ptbd_pkg::D2_LIMBS][ptbd_pkg::S_LIMBS];
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < ptbd_pkg::D2_LIMBS; i++) begin
                for (int j = 0; j < ptbd_pkg::S_LIMBS; j++) begin
                    r_pp[i][j] <= w_d2p[i*LIMB_W +: LIMB_W] * w_sp[j*LIMB_W +: LIMB_W];
                end
            end
        end
    end

    // even and odd products of a row do not overlap, so each side is a concatenation
    logic [ptbd_pkg::ROW_W-1:0] w_ev  [ptbd_pkg::D2_LIMBS];
    logic [ptbd_pkg::ROW_W-1:0] w_od  [ptbd_pkg::D2_LIMBS];
    logic [ptbd_pkg::ROW_W-1:0] r_row [ptbd_pkg::D2_LIMBS];
    always_comb begin
        for (int i = 0; i < ptbd_pkg::D2_LIMBS; i++) begin
            w_ev[i] = '0;
            w_od[i] = '0;
            for (int j = 0; j < ptbd_pkg::S_LIMBS; j++) begin
                if ((j & 1) == 0) begin
                    w_ev[i][j*LIMB_W +: 2*LIMB_W] = r_pp[i][j];
                end else begin
                    w_od[i][j*LIMB_W +: 2*LIMB_W] = r_pp[i][j];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < ptbd_pkg::D2_LIMBS; i++) begin
                r_row[i] <= w_ev[i] + w_od[i];
            end
        end
    end

    logic [ptbd_pkg::HALF_W-1:0] r_half [ptbd_pkg::HALF_N];
    for (genvar h = 0; h < ptbd_pkg::HALF_N; h++) begin : g_half
        if (2 * h + 1 < ptbd_pkg::D2_LIMBS) begin : g_two
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_half[h] <= ptbd_pkg::HALF_W'(r_row[2*h])
                               + (ptbd_pkg::HALF_W'(r_row[2*h+1]) << LIMB_W);
                end
            end
        end else begin : g_one
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_half[h] <= ptbd_pkg::HALF_W'(r_row[2*h]);
                end
            end
        end
    end

    logic [ptbd_pkg::ACC_W-1:0] w_acc;
    logic [DEN_W-1:0]           r_den;
    always_comb begin
        w_acc = '0;
        for (int h = 0; h < ptbd_pkg::HALF_N; h++) begin
            w_acc = w_acc + (ptbd_pkg::ACC_W'(r_half[h]) << (2 * LIMB_W * h));
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_den <= w_acc[DEN_W-1:0];
        end
    end

    // division: clamp check, then one quotient bit per stage, x and y side by side
    logic [PREM_W-1:0] r_pr    [QUO_W+1][2];
    logic [QUO_W-1:0]  r_q     [QUO_W+1][2];
    logic              r_clamp [QUO_W+1][2];
    logic [DEN_W-1:0]  r_dv    [QUO_W+1];
    logic [PREM_W-1:0] w_r0    [2];
    logic [MAG_W-1:0]  w_mag   [2];

    assign w_mag[0] = r_side[ptbd_pkg::CLAMP_STAGE-1].ax;
    assign w_mag[1] = r_side[ptbd_pkg::CLAMP_STAGE-1].ay;

    always_comb begin
        for (int c = 0; c < 2; c++) begin
            w_r0[c] = PREM_W'(w_mag[c]) << ptbd_pkg::NUM_SHIFT;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int c = 0; c < 2; c++) begin
                r_pr[0][c]    <= w_r0[c];
                r_q[0][c]     <= '0;
                r_clamp[0][c] <= w_r0[c] >= PREM_W'(r_den);
            end
            r_dv[0] <= r_den;
        end
    end

    for (genvar k = 1; k <= QUO_W; k++) begin : g_div
        logic [PREM_W-1:0] w_sh [2];
        logic              w_ge [2];
        always_comb begin
            for (int c = 0; c < 2; c++) begin
                w_sh[c] = {r_pr[k-1][c][PREM_W-2:0], 1'b0};
                w_ge[c] = w_sh[c] >= PREM_W'(r_dv[k-1]);
            end
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                for (int c = 0; c < 2; c++) begin
                    r_pr[k][c]    <= w_ge[c] ? (w_sh[c] - PREM_W'(r_dv[k-1])) : w_sh[c];
                    r_q[k][c]     <= {r_q[k-1][c][QUO_W-2:0], w_ge[c]};
                    r_clamp[k][c] <= r_clamp[k-1][c];
                end
                r_dv[k] <= r_dv[k-1];
            end
        end
    end

    // term stage: zero distance wins, then the clamp, then the signed quotient
    t_side             w_last;
    logic              w_zero;
    logic [TERM_W-1:0] w_mx, w_my;
    ptbd_pkg::t_term   r_tx, r_ty;
    logic              r_fault;

    assign w_last = r_side[SIDE_N];
    assign w_zero = (w_last.ax == '0) && (w_last.ay == '0);

    always_comb begin
        if (w_zero) begin
            w_mx = '0;
            w_my = '0;
        end else begin
            w_mx = r_clamp[QUO_W][0] ? (TERM_W'(1) << QUO_W) : TERM_W'(r_q[QUO_W][0]);
            w_my = r_clamp[QUO_W][1] ? (TERM_W'(1) << QUO_W) : TERM_W'(r_q[QUO_W][1]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_tx    <= w_last.sx ? TERM_W'(-w_mx) : w_mx;
            r_ty    <= w_last.sy ? TERM_W'(-w_my) : w_my;
            r_fault <= w_zero || r_clamp[QUO_W][0] || r_clamp[QUO_W][1];
        end
    end

    assign o_tx    = r_tx;
    assign o_ty    = r_ty;
    assign o_fault = r_fault;

endmodule

// ===== design/planar_three_body_derivative.sv =====
// planar three-body derivative, equal unit masses, center of mass at the origin
// request channel i_req carries positions and momenta of bodies one and two,
// result channel o_rsp carries the state derivative and a range fault flag.
// values are signed 64-bit fixed point with FRAC_BITS fraction bits.
// rates are the momenta unchanged; forces are -t12 - t13 and t12 - t23 with
// t = d / |d|^3, saturated to 64 bits. range_fault flags a zero pair distance,
// a term clamped at 2^63 or a saturated force.
// throughput: one request per cycle while no result is stalled on o_rsp; the
// depth is set by the 130-stage square root and 63-stage divider
// of each pair unit, all three pair units working in parallel.
// the whole pipe advances together; while a result waits on o_rsp with ready
// low, i_req.ready drops and every stage holds, nothing is lost or repeated.
// empty stages do not block: ready stays high while the output is empty.
// reset (i_rst_n low, synchronous) clears only the valid bits, so the pipe
// is empty and ready right after reset.
// depends on ptbd_pkg, ptbd_if and ptbd_pair
module planar_three_body_derivative (
    input  logic       i_clk,
    input  logic       i_rst_n,
    ptbd_in_if.sink    i_req,
    ptbd_out_if.source o_rsp
);
    localparam int LAT    = ptbd_pkg::LAT;
    localparam int WORD_W = ptbd_pkg::WORD_W;
    localparam int DIFF_W = ptbd_pkg::DIFF_W;
    localparam int SUM_W  = ptbd_pkg::SUM_W;

    typedef struct packed {
        ptbd_pkg::t_word x1;
        ptbd_pkg::t_word y1;
        ptbd_pkg::t_word x2;
        ptbd_pkg::t_word y2;
    } t_mom;

    typedef struct packed {
        logic            flag;
        ptbd_pkg::t_word value;
    } t_sat;

    function automatic t_sat sat_word(input logic signed [SUM_W-1:0] v);
        t_sat res;
        if ((v[SUM_W-1:WORD_W-1] == '0) || (v[SUM_W-1:WORD_W-1] == '1)) begin
            res.flag  = 1'b0;
            res.value = v[WORD_W-1:0];
        end else begin
            res.flag  = 1'b1;
            res.value = v[SUM_W-1] ? {1'b1, {(WORD_W-1){1'b0}}} : {1'b0, {(WORD_W-1){1'b1}}};
        end
        return res;
    endfunction

    logic             w_en;
    logic [LAT-1:0]   r_vld;

    assign w_en        = !r_vld[LAT-1] || o_rsp.ready;
    assign i_req.ready = w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[LAT-2:0], i_req.valid};
        end
    end

    // momenta ride alongside the arithmetic
    t_mom r_mom [LAT-1];
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_mom[0] <= '{x1: i_req.mom_x1, y1: i_req.mom_y1,
                          x2: i_req.mom_x2, y2: i_req.mom_y2};
            for (int k = 1; k < LAT - 1; k++) begin
                r_mom[k] <= r_mom[k-1];
            end
        end
    end

    // pair differences; body three sits at -(r1 + r2)
    ptbd_pkg::t_diff r_dx12, r_dy12, r_dx13, r_dy13, r_dx23, r_dy23;
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_dx12 <= DIFF_W'(i_req.pos_x1) - DIFF_W'(i_req.pos_x2);
            r_dy12 <= DIFF_W'(i_req.pos_y1) - DIFF_W'(i_req.pos_y2);
            r_dx13 <= (DIFF_W'(i_req.pos_x1) <<< 1) + DIFF_W'(i_req.pos_x2);
            r_dy13 <= (DIFF_W'(i_req.pos_y1) <<< 1) + DIFF_W'(i_req.pos_y2);
            r_dx23 <= (DIFF_W'(i_req.pos_x2) <<< 1) + DIFF_W'(i_req.pos_x1);
            r_dy23 <= (DIFF_W'(i_req.pos_y2) <<< 1) + DIFF_W'(i_req.pos_y1);
        end
    end

    ptbd_pkg::t_term w_tx12, w_ty12, w_tx13, w_ty13, w_tx23, w_ty23;
    logic            w_f12, w_f13, w_f23;

    ptbd_pair u_pair12 (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_dx    (r_dx12),
        .i_dy    (r_dy12),
        .o_tx    (w_tx12),
        .o_ty    (w_ty12),
        .o_fault (w_f12)
    );

    ptbd_pair u_pair13 (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_dx    (r_dx13),
        .i_dy    (r_dy13),
        .o_tx    (w_tx13),
        .o_ty    (w_ty13),
        .o_fault (w_f13)
    );

    ptbd_pair u_pair23 (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_dx    (r_dx23),
        .i_dy    (r_dy23),
        .o_tx    (w_tx23),
        .o_ty    (w_ty23),
        .o_fault (w_f23)
    );

    // exact force sums
    logic signed [SUM_W-1:0] r_fx1, r_fy1, r_fx2, r_fy2;
    logic                    r_pfault;
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_fx1    <= -(SUM_W'(w_tx12) + SUM_W'(w_tx13));
            r_fy1    <= -(SUM_W'(w_ty12) + SUM_W'(w_ty13));
            r_fx2    <= SUM_W'(w_tx12) - SUM_W'(w_tx23);
            r_fy2    <= SUM_W'(w_ty12) - SUM_W'(w_ty23);
            r_pfault <= w_f12 || w_f13 || w_f23;
        end
    end

    t_sat n_sx1, n_sy1, n_sx2, n_sy2;
    always_comb begin
        n_sx1 = sat_word(r_fx1);
        n_sy1 = sat_word(r_fy1);
        n_sx2 = sat_word(r_fx2);
        n_sy2 = sat_word(r_fy2);
    end

    // output register
    t_mom            r_out_rate;
    ptbd_pkg::t_word r_out_fx1, r_out_fy1, r_out_fx2, r_out_fy2;
    logic            r_out_fault;
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out_rate  <= r_mom[LAT-2];
            r_out_fx1   <= n_sx1.value;
            r_out_fy1   <= n_sy1.value;
            r_out_fx2   <= n_sx2.value;
            r_out_fy2   <= n_sy2.value;
            r_out_fault <= r_pfault || n_sx1.flag || n_sy1.flag || n_sx2.flag || n_sy2.flag;
        end
    end

    assign o_rsp.valid       = r_vld[LAT-1];
    assign o_rsp.rate_x1     = r_out_rate.x1;
    assign o_rsp.rate_y1     = r_out_rate.y1;
    assign o_rsp.rate_x2     = r_out_rate.x2;
    assign o_rsp.rate_y2     = r_out_rate.y2;
    assign o_rsp.force_x1    = r_out_fx1;
    assign o_rsp.force_y1    = r_out_fy1;
    assign o_rsp.force_x2    = r_out_fx2;
    assign o_rsp.force_y2    = r_out_fy2;
    assign o_rsp.range_fault = r_out_fault;

endmodule

// ===== design/ptbd_chk.sv =====
// port-level checker for the planar three-body derivative, bound to the top
// depends on ptbd_pkg and the macro header
`include "planar_three_body_derivative_macros.svh"

module ptbd_chk (
    input logic            i_clk,
    input logic            i_rst_n,
    input logic            i_req_ready,
    input logic            i_rsp_valid,
    input logic            i_rsp_ready,
    input ptbd_pkg::t_word i_force_x1,
    input logic            i_range_fault
);
    // pipe is empty right after reset
    `PTBD_ASSERT_RST(a_rst_empty, !i_rst_n, !i_rsp_valid, "result valid after reset")

    // an empty output never blocks requests
    `PTBD_ASSERT_NOW(a_ready_free, !i_rsp_valid, i_req_ready, "request refused with empty output")

    // a stalled result freezes the whole pipe
    `PTBD_ASSERT_NOW(a_stall_block, i_rsp_valid && !i_rsp_ready, !i_req_ready,
        "request taken while result stalled")

    // stalled result holds
    `PTBD_ASSERT_NEXT(a_rsp_hold, i_rsp_valid && !i_rsp_ready,
        i_rsp_valid && $stable(i_force_x1) && $stable(i_range_fault), "stalled result changed")

endmodule

bind planar_three_body_derivative ptbd_chk u_ptbd_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_req_ready   (i_req.ready),
    .i_rsp_valid   (o_rsp.valid),
    .i_rsp_ready   (o_rsp.ready),
    .i_force_x1    (o_rsp.force_x1),
    .i_range_fault (o_rsp.range_fault)
);

// ===== dv/planar_three_body_derivative_test.sv =====
// self-checking bench for planar_three_body_derivative: random and corner-case states
// with exact-integer force prediction; depends on ptbd_pkg, ptbd_if and the rtl
module planar_three_body_derivative_test;
    timeunit 1ns;
    timeprecision 1ps;

    typedef logic [383:0] t_big;
    typedef logic signed [65:0] t_wide;

    typedef struct {
        ptbd_pkg::t_word pos[4];
        ptbd_pkg::t_word mom[4];
    } t_state;

    typedef struct {
        ptbd_pkg::t_word word[8];
        logic            fault;
    } t_deriv;

    logic i_clk;
    logic i_rst_n;
    ptbd_in_if  req_if();
    ptbd_out_if rsp_if();

    planar_three_body_derivative dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    t_state state_queue[$];
    t_deriv deriv_queue[$];
    int     cycle_count;
    logic   failed;

    function automatic t_big root_floor(input t_big x);
        t_big r, c;
        r = '0;
        for (int i = 140; i >= 0; i--) begin
            c = r | (t_big'(1) << i);
            if (c * c <= x) r = c;
        end
        return r;
    endfunction

    // term = d / |d|^3, magnitude truncated, clamped at 2^63
    function automatic void pair_pull(input t_wide dx, input t_wide dy,
                                      output t_wide tx, output t_wide ty,
                                      inout logic fault);
        t_big ax, ay, d2, den, q;
        t_wide dc[2];
        t_wide tc[2];
        dc[0] = dx;
        dc[1] = dy;
        ax = t_big'($unsigned(dx < 0 ? -dx : dx));
        ay = t_big'($unsigned(dy < 0 ? -dy : dy));
        d2 = ax * ax + ay * ay;
        if (d2 == 0) begin
            tx = '0;
            ty = '0;
            fault = 1'b1;
            return;
        end
        den = d2 * root_floor(d2 << 128);
        for (int k = 0; k < 2; k++) begin
            q = (t_big'($unsigned(dc[k] < 0 ? -dc[k] : dc[k]))
                 << (3 * ptbd_pkg::FRAC_BITS + 64)) / den;
            if (q >= (t_big'(1) << 63)) begin
                q = t_big'(1) << 63;
                fault = 1'b1;
            end
            tc[k] = dc[k] < 0 ? -$signed(q[65:0]) : $signed(q[65:0]);
        end
        tx = tc[0];
        ty = tc[1];
    endfunction

    function automatic ptbd_pkg::t_word clip_word(input logic signed [67:0] s,
                                                  inout logic fault);
        if (s > 68'sh0_7FFF_FFFF_FFFF_FFFF) begin
            fault = 1'b1;
            return 64'sh7FFF_FFFF_FFFF_FFFF;
        end
        if (s < -68'sh0_8000_0000_0000_0000) begin
            fault = 1'b1;
            return 64'sh8000_0000_0000_0000;
        end
        return s[63:0];
    endfunction

    function automatic t_deriv derive_state(input t_state st);
        t_deriv d;
        t_wide x1, y1, x2, y2;
        t_wide t12x, t12y, t13x, t13y, t23x, t23y;
        logic signed [67:0] s;
        logic fault;
        fault = 1'b0;
        x1 = st.pos[0];
        y1 = st.pos[1];
        x2 = st.pos[2];
        y2 = st.pos[3];
        pair_pull(x1 - x2, y1 - y2, t12x, t12y, fault);
        pair_pull(x1 + x1 + x2, y1 + y1 + y2, t13x, t13y, fault);
        pair_pull(x2 + x2 + x1, y2 + y2 + y1, t23x, t23y, fault);
        for (int i = 0; i < 4; i++) d.word[i] = st.mom[i];
        s = -(t12x + t13x);
        d.word[4] = clip_word(s, fault);
        s = -(t12y + t13y);
        d.word[5] = clip_word(s, fault);
        s = t12x - t23x;
        d.word[6] = clip_word(s, fault);
        s = t12y - t23y;
        d.word[7] = clip_word(s, fault);
        d.fault = fault;
        return d;
    endfunction

    function automatic ptbd_pkg::t_word rand_coord();
        ptbd_pkg::t_word w;
        w = {$urandom, $urandom};
        case ($urandom_range(0, 3))
            0: return w;
            1: return w >>> $urandom_range(0, 63);
            2: return w >>> $urandom_range(12, 18);  // around unit scale
            default: return w >>> $urandom_range(40, 63);
        endcase
    endfunction

    function automatic void add_state(input ptbd_pkg::t_word x1, input ptbd_pkg::t_word y1,
                                      input ptbd_pkg::t_word x2, input ptbd_pkg::t_word y2);
        t_state st;
        st.pos[0] = x1;
        st.pos[1] = y1;
        st.pos[2] = x2;
        st.pos[3] = y2;
        for (int i = 0; i < 4; i++) st.mom[i] = {$urandom, $urandom};
        state_queue.push_back(st);
    endfunction

    // idle about 15 percent of the time, except for a quiet window in each period
    function automatic logic take_break();
        return (cycle_count % 3000) >= 700 && $urandom_range(0, 99) < 15;
    endfunction

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) cycle_count <= cycle_count + 1;

    // request driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            req_if.valid <= 1'b0;
        end else if (!req_if.valid || req_if.ready) begin
            if (state_queue.size() != 0 && !take_break()) begin
                t_state st;
                st = state_queue.pop_front();
                req_if.valid  <= 1'b1;
                req_if.pos_x1 <= st.pos[0];
                req_if.pos_y1 <= st.pos[1];
                req_if.pos_x2 <= st.pos[2];
                req_if.pos_y2 <= st.pos[3];
                req_if.mom_x1 <= st.mom[0];
                req_if.mom_y1 <= st.mom[1];
                req_if.mom_x2 <= st.mom[2];
                req_if.mom_y2 <= st.mom[3];
            end else begin
                req_if.valid <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) rsp_if.ready <= 1'b0;
        else rsp_if.ready <= !take_break();
    end

    // predict on accepted request, check on accepted result
    always @(posedge i_clk) begin
        if (i_rst_n && req_if.valid && req_if.ready) begin
            t_state st;
            st.pos[0] = req_if.pos_x1;
            st.pos[1] = req_if.pos_y1;
            st.pos[2] = req_if.pos_x2;
            st.pos[3] = req_if.pos_y2;
            st.mom[0] = req_if.mom_x1;
            st.mom[1] = req_if.mom_y1;
            st.mom[2] = req_if.mom_x2;
            st.mom[3] = req_if.mom_y2;
            deriv_queue.push_back(derive_state(st));
        end
        if (i_rst_n && rsp_if.valid && rsp_if.ready) begin
            t_deriv got, want;
            got.word[0] = rsp_if.rate_x1;
            got.word[1] = rsp_if.rate_y1;
            got.word[2] = rsp_if.rate_x2;
            got.word[3] = rsp_if.rate_y2;
            got.word[4] = rsp_if.force_x1;
            got.word[5] = rsp_if.force_y1;
            got.word[6] = rsp_if.force_x2;
            got.word[7] = rsp_if.force_y2;
            got.fault   = rsp_if.range_fault;
            if (deriv_queue.size() == 0) begin
                $display("%0t: unexpected result", $time);
                failed = 1'b1;
            end else begin
                want = deriv_queue.pop_front();
                for (int i = 0; i < 8; i++) begin
                    if (got.word[i] !== want.word[i]) begin
                        $display("%0t: word %0d expected %h actual %h",
                                 $time, i, want.word[i], got.word[i]);
                        failed = 1'b1;
                    end
                end
                if (got.fault !== want.fault) begin
                    $display("%0t: range_fault expected %b actual %b",
                             $time, want.fault, got.fault);
                    failed = 1'b1;
                end
            end
        end
    end

    initial begin
        ptbd_pkg::t_word big_p, big_n, one;
        big_p = 64'sh7FFF_FFFF_FFFF_FFFF;
        big_n = 64'sh8000_0000_0000_0000;
        one   = ptbd_pkg::t_word'(1) <<< ptbd_pkg::FRAC_BITS;
        failed = 1'b0;
        cycle_count = 0;
        i_rst_n = 1'b0;
        req_if.valid = 1'b0;
        req_if.pos_x1 = '0;
        req_if.pos_y1 = '0;
        req_if.pos_x2 = '0;
        req_if.pos_y2 = '0;
        req_if.mom_x1 = '0;
        req_if.mom_y1 = '0;
        req_if.mom_x2 = '0;
        req_if.mom_y2 = '0;
        rsp_if.ready = 1'b0;

        // all at origin: every distance zero
        add_state(0, 0, 0, 0);
        // bodies one and two coincide
        add_state(one, one, one, one);
        // body three meets body one
        add_state(one, 0, -(one + one), 0);
        add_state(one, -one, 0, 0);
        add_state(0, one, -one, 0);
        add_state(big_p, big_p, big_p, big_p);
        add_state(big_n, big_n, big_n, big_n);
        add_state(big_p, big_n, big_n, big_p);
        add_state(big_n, big_p, big_p, big_n);
        add_state(big_p, 0, big_n, 0);
        // tiny spacings clamp the terms and saturate the forces
        add_state(1, 0, 0, 0);
        add_state(1, 1, -1, 2);
        add_state(-1, -1, 1, -1);
        add_state(one, 1, one + 1, 0);
        add_state(-one, 0, one, 0);
        add_state(one >>> 10, 0, 0, one >>> 10);
        for (int n = 0; n < 1650; n++) begin
            ptbd_pkg::t_word x1, y1;
            x1 = rand_coord();
            y1 = rand_coord();
            case ($urandom_range(0, 9))
                0: add_state(x1, y1, x1 + ($urandom_range(0, 15) - 8), y1 + $urandom_range(0, 3));
                1: add_state(x1, y1, -(x1 + x1) + $urandom_range(0, 7), -(y1 + y1));
                default: add_state(x1, y1, rand_coord(), rand_coord());
            endcase
        end

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        while (state_queue.size() != 0 || req_if.valid || deriv_queue.size() != 0)
            @(posedge i_clk);
        repeat (ptbd_pkg::LAT + 20) @(posedge i_clk);
        if (!failed && deriv_queue.size() == 0) begin
            $display("planar_three_body_derivative_test: PASS");
        end else begin
            $display("planar_three_body_derivative_test: FAIL");
        end
        $finish;
    end

    initial begin
        #2ms;
        $display("planar_three_body_derivative_test: FAIL");
        $finish;
    end
endmodule

// ===== files.f =====
+incdir+design
design/ptbd_pkg.sv
design/ptbd_if.sv
design/ptbd_pair.sv
design/planar_three_body_derivative.sv
design/ptbd_chk.sv
dv/planar_three_body_derivative_test.sv
